@@ src/order_book_price_level_engine_assert.svh @@
// assertion macros for the price level engine
`ifndef ORDER_BOOK_PRICE_LEVEL_ENGINE_ASSERT_SVH
`define ORDER_BOOK_PRICE_LEVEL_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OBPLE_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("obple assertion failed");
`define OBPLE_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("obple assertion failed");
`else
`define OBPLE_ASSERT_IMP(lbl, pre, post)
`define OBPLE_ASSERT_NXT(lbl, pre, post)
`endif
`endif

@@ src/obple_pkg.sv @@
// shared types, constants and helpers of the price level engine
`default_nettype none
package obple_pkg;
  localparam int LEVELS  = 64;
  localparam int NTABLES = 6;
  localparam int NSLOTS  = NTABLES * LEVELS;
  localparam int IDX_W   = $clog2(LEVELS);
  localparam int SLOT_W  = $clog2(NSLOTS);

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REDUCE = 2'd1;
  localparam logic [1:0] BOOK_TRAIL  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_UNDER   = 2'd3;

  localparam logic [1:0] KIND_ADDED   = 2'd0;
  localparam logic [1:0] KIND_UPDATED = 2'd1;
  localparam logic [1:0] KIND_DELETED = 2'd2;

  localparam logic [2:0] TAB_BID       = 3'd0;
  localparam logic [2:0] TAB_SELL_STOP = 3'd3;
  localparam logic [2:0] TAB_SELL_TRL  = 3'd5;

  typedef struct packed {
    logic        used;
    logic [31:0] price;
    logic [47:0] total;
    logic [47:0] hidden;
    logic [47:0] visible;
    logic [15:0] orders;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef struct packed {
    logic              capture;
    logic              clear;
    logic              rd;
    logic              rescan;
    logic              update;
    logic              load_out;
    logic [SLOT_W-1:0] cnt;
  } obple_cmd_t;

  typedef struct packed {
    logic need_rescan;
    logic out_free;
  } obple_stat_t;

  function automatic logic better(input logic [2:0] t, input logic [31:0] a,
                                  input logic [31:0] b);
    logic hib;
    hib = (t == TAB_BID) || (t == TAB_SELL_STOP) || (t == TAB_SELL_TRL);
    return hib ? (a > b) : (a < b);
  endfunction

  function automatic logic [47:0] sat_add(input logic [47:0] v, input logic [31:0] d);
    logic [48:0] s;
    s = {1'b0, v} + {17'b0, d};
    return s[48] ? '1 : s[47:0];
  endfunction
endpackage
`default_nettype wire

@@ src/obple_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module obple_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ src/obple_ctrl.sv @@
// controller: clearing pass, level scan, update, best rescan, result hand-off
`default_nettype none
module obple_ctrl import obple_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire obple_stat_t stat,
  output obple_cmd_t       cmd
);
  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_UPD    = 3'd4;
  localparam logic [2:0] S_RSCAN  = 3'd5;
  localparam logic [2:0] S_RDRAIN = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clear = 1'b1;
        if (cnt_r == SLOT_W'(NSLOTS - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SCAN;
          cnt_nxt     = '0;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (cnt_r == SLOT_W'(LEVELS - 1)) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: state_nxt = S_UPD;
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = stat.need_rescan ? S_RSCAN : S_FIN;
      end
      S_RSCAN: begin
        cmd.rd     = 1'b1;
        cmd.rescan = 1'b1;
        if (cnt_r == SLOT_W'(LEVELS - 1)) begin
          state_nxt = S_RDRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RDRAIN: begin
        cmd.rescan = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
endmodule
`default_nettype wire

@@ src/obple_dp.sv @@
// datapath: level store, scan trackers, best level registers, result register
`default_nettype none
module obple_dp import obple_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire obple_cmd_t  cmd,
  output obple_stat_t      stat,
  input  wire logic [1:0]  in_func,
  input  wire logic [1:0]  in_book,
  input  wire logic        in_side,
  input  wire logic [31:0] in_price,
  input  wire logic [31:0] in_quantity,
  input  wire logic [31:0] in_hidden_quantity,
  input  wire logic [31:0] in_visible_quantity,
  input  wire logic        in_order_done,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [1:0]       out_update_kind,
  output logic [31:0]      out_level_price,
  output logic [47:0]      out_total_volume,
  output logic [47:0]      out_hidden_volume,
  output logic [47:0]      out_visible_volume,
  output logic [15:0]      out_order_count,
  output logic             out_is_top,
  output logic [31:0]      out_best_price,
  output logic             out_best_valid
);
  // latched word
  logic [1:0]  func_r;
  logic [2:0]  t_r;
  logic [31:0] price_r, qty_r, hid_r, vis_r;
  logic        done_r;

  // scan trackers
  logic             rd_v_r, found_r, free_r;
  logic [IDX_W-1:0] ridx_r, fidx_r, freeidx_r;
  slot_t            cap_r;

  // best level per table
  logic [NTABLES-1:0] best_present_r;
  logic [IDX_W-1:0]   best_slot_r  [NTABLES];
  logic [31:0]        best_price_r [NTABLES];

  // result of the update step
  logic [1:0]  res_status_r, res_kind_r;
  logic [47:0] res_tot_r, res_hid_r, res_vis_r;
  logic [15:0] res_cnt_r;
  logic        res_top_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r, out_kind_r;
  logic [31:0] out_price_r, out_best_price_r;
  logic [47:0] out_tot_r, out_hid_r, out_vis_r;
  logic [15:0] out_cnt_r;
  logic        out_top_r, out_best_valid_r;

  logic [SLOT_BITS-1:0] rdata;
  slot_t                rword, bw, wword;
  logic [SLOT_W-1:0]    base, waddr, raddr;
  logic                 we, wr_en;
  logic [IDX_W-1:0]     idx;
  logic                 is_add, bp, new_best, dec, under, need_rescan;
  logic [IDX_W-1:0]     bs;
  logic [31:0]          bpr;
  logic [1:0]           st, kind;
  logic                 top;
  logic [47:0]          n_tot, n_hid, n_vis;
  logic [15:0]          n_cnt;

  assign rword = slot_t'(rdata);
  assign base  = SLOT_W'(t_r) * SLOT_W'(LEVELS);
  assign raddr = base + SLOT_W'(cmd.cnt[IDX_W-1:0]);
  assign waddr = cmd.clear ? cmd.cnt : base + SLOT_W'(idx);
  assign we    = cmd.clear | (cmd.update & wr_en);

  obple_ram #(.WIDTH(SLOT_BITS), .DEPTH(NSLOTS)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(cmd.clear ? '0 : SLOT_BITS'(wword)),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign bp  = best_present_r[t_r];
  assign bs  = best_slot_r[t_r];
  assign bpr = best_price_r[t_r];

  always_comb begin
    is_add   = (func_r == FUNC_ADD);
    idx      = found_r ? fidx_r : freeidx_r;
    dec      = (func_r != FUNC_REDUCE) || done_r;
    bw       = cap_r;
    if (!found_r) begin
      bw       = '0;
      bw.used  = 1'b1;
      bw.price = price_r;
    end
    new_best    = is_add && !found_r && free_r && (!bp || better(t_r, price_r, bpr));
    under       = 1'b0;
    need_rescan = 1'b0;
    wr_en       = 1'b0;
    st          = ST_OK;
    kind        = KIND_UPDATED;
    top         = 1'b0;
    n_tot       = '0;
    n_hid       = '0;
    n_vis       = '0;
    n_cnt       = '0;
    wword       = bw;
    if (is_add) begin
      kind = found_r ? KIND_UPDATED : KIND_ADDED;
      if (!found_r && !free_r) begin
        st = ST_FULL;
      end else begin
        wr_en = 1'b1;
        n_tot = sat_add(bw.total, qty_r);
        n_hid = sat_add(bw.hidden, hid_r);
        n_vis = sat_add(bw.visible, vis_r);
        n_cnt = (bw.orders == 16'hFFFF) ? bw.orders : bw.orders + 16'd1;
        top   = new_best || (bp && bs == idx);
      end
    end else if (!found_r) begin
      st = ST_MISSING;
    end else begin
      wr_en = 1'b1;
      if ({16'b0, qty_r} > bw.total) under = 1'b1;
      else n_tot = bw.total - {16'b0, qty_r};
      if ({16'b0, hid_r} > bw.hidden) under = 1'b1;
      else n_hid = bw.hidden - {16'b0, hid_r};
      if ({16'b0, vis_r} > bw.visible) under = 1'b1;
      else n_vis = bw.visible - {16'b0, vis_r};
      n_cnt = bw.orders;
      if (dec) begin
        if (bw.orders == 16'd0) under = 1'b1;
        else n_cnt = bw.orders - 16'd1;
      end
      if (under) st = ST_UNDER;
      if (n_tot == 48'd0) begin
        kind        = KIND_DELETED;
        top         = 1'b1;
        need_rescan = bp && (bs == idx);
      end else begin
        top = bp && (bs == idx);
      end
    end
    wword.total   = n_tot;
    wword.hidden  = n_hid;
    wword.visible = n_vis;
    wword.orders  = n_cnt;
    wword.used    = !(kind == KIND_DELETED);
  end

  assign stat.need_rescan = need_rescan;
  assign stat.out_free    = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      t_r     <= {(in_book > BOOK_TRAIL) ? BOOK_TRAIL : in_book, in_side};
      price_r <= in_price;
      qty_r   <= in_quantity;
      hid_r   <= in_hidden_quantity;
      vis_r   <= in_visible_quantity;
      done_r  <= in_order_done;
    end
    ridx_r <= cmd.cnt[IDX_W-1:0];
    if (rd_v_r && !cmd.rescan) begin
      if (rword.used && rword.price == price_r && !found_r) begin
        fidx_r <= ridx_r;
        cap_r  <= rword;
      end
      if (!rword.used && !free_r) freeidx_r <= ridx_r;
    end
    if (cmd.update) begin
      res_status_r <= st;
      res_kind_r   <= kind;
      res_tot_r    <= n_tot;
      res_hid_r    <= n_hid;
      res_vis_r    <= n_vis;
      res_cnt_r    <= n_cnt;
      res_top_r    <= top;
    end
    if (cmd.load_out) begin
      out_status_r     <= res_status_r;
      out_kind_r       <= res_kind_r;
      out_price_r      <= price_r;
      out_tot_r        <= res_tot_r;
      out_hid_r        <= res_hid_r;
      out_vis_r        <= res_vis_r;
      out_cnt_r        <= res_cnt_r;
      out_top_r        <= res_top_r;
      out_best_valid_r <= bp;
      out_best_price_r <= bp ? bpr : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r         <= 1'b0;
      found_r        <= 1'b0;
      free_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      best_present_r <= '0;
      for (int i = 0; i < NTABLES; i++) begin
        best_slot_r[i]  <= '0;
        best_price_r[i] <= '0;
      end
    end else begin
      rd_v_r <= cmd.rd;
      if (cmd.capture) begin
        found_r <= 1'b0;
        free_r  <= 1'b0;
      end else if (rd_v_r && !cmd.rescan) begin
        if (rword.used && rword.price == price_r) found_r <= 1'b1;
        if (!rword.used) free_r <= 1'b1;
      end
      if (cmd.update) begin
        if (new_best) begin
          best_present_r[t_r] <= 1'b1;
          best_slot_r[t_r]    <= idx;
          best_price_r[t_r]   <= price_r;
        end
        if (need_rescan) begin
          best_present_r[t_r] <= 1'b0;
          best_slot_r[t_r]    <= '0;
        end
      end
      // rescan keeps the best of the used entries seen so far
      if (rd_v_r && cmd.rescan && rword.used &&
          (!bp || better(t_r, rword.price, bpr))) begin
        best_present_r[t_r] <= 1'b1;
        best_slot_r[t_r]    <= ridx_r;
        best_price_r[t_r]   <= rword.price;
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_update_kind    = out_kind_r;
  assign out_level_price    = out_price_r;
  assign out_total_volume   = out_tot_r;
  assign out_hidden_volume  = out_hid_r;
  assign out_visible_volume = out_vis_r;
  assign out_order_count    = out_cnt_r;
  assign out_is_top         = out_top_r;
  assign out_best_price     = out_best_price_r;
  assign out_best_valid     = out_best_valid_r;
endmodule
`default_nettype wire

@@ src/order_book_price_level_engine.sv @@
// Price level engine: six tables (limit bid/ask, buy/sell stop, trailing buy/sell
// stop) of LEVELS levels each, held in one shared RAM with one read and one write
// port. After reset a clearing pass over all 6*LEVELS slots (384 at LEVELS=64)
// runs with in_stall high.
// Each word then runs a linear scan of its table over the RAM read port to find
// the level and a free slot, then an update step and a result step; freeing the
// best level adds another scan of the table for the next best. One word is worked
// on at a time; the result register holds while stalled.
`default_nettype none
`include "order_book_price_level_engine_assert.svh"
module order_book_price_level_engine import obple_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [1:0]  in_book,
  input  wire logic        in_side,
  input  wire logic [31:0] in_price,
  input  wire logic [31:0] in_quantity,
  input  wire logic [31:0] in_hidden_quantity,
  input  wire logic [31:0] in_visible_quantity,
  input  wire logic        in_order_done,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [1:0]       out_update_kind,
  output logic [31:0]      out_level_price,
  output logic [47:0]      out_total_volume,
  output logic [47:0]      out_hidden_volume,
  output logic [47:0]      out_visible_volume,
  output logic [15:0]      out_order_count,
  output logic             out_is_top,
  output logic [31:0]      out_best_price,
  output logic             out_best_valid
);
  obple_cmd_t  cmd;
  obple_stat_t stat;

  obple_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  obple_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_func            (in_func),
    .in_book            (in_book),
    .in_side            (in_side),
    .in_price           (in_price),
    .in_quantity        (in_quantity),
    .in_hidden_quantity (in_hidden_quantity),
    .in_visible_quantity(in_visible_quantity),
    .in_order_done      (in_order_done),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_update_kind    (out_update_kind),
    .out_level_price    (out_level_price),
    .out_total_volume   (out_total_volume),
    .out_hidden_volume  (out_hidden_volume),
    .out_visible_volume (out_visible_volume),
    .out_order_count    (out_order_count),
    .out_is_top         (out_is_top),
    .out_best_price     (out_best_price),
    .out_best_valid     (out_best_valid)
  );

  // busy right after taking a word
  `OBPLE_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a new result only appears at the end of a word's work
  `OBPLE_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(in_stall))
endmodule
`default_nettype wire
